// ===== hw/rtl/preference_closure_store_assert.svh =====
// Assertion macros shared by the preference closure store modules.
`ifndef PREFERENCE_CLOSURE_STORE_ASSERT_SVH
`define PREFERENCE_CLOSURE_STORE_ASSERT_SVH

`ifndef SYNTH

// Condition must hold one cycle, consequence in the same cycle.
`define PCS_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pcs: implication check failed");

// Condition must hold one cycle, consequence in the following cycle.
`define PCS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pcs: next-cycle check failed");

// Condition must never be seen.
`define PCS_ASSERT_NEVER(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(cond)) \
    else $error("pcs: forbidden condition seen");

`else

`define PCS_ASSERT_IMPL(lbl, ck, rs, ante, cons)
`define PCS_ASSERT_NEXT(lbl, ck, rs, ante, cons)
`define PCS_ASSERT_NEVER(lbl, ck, rs, cond)

`endif

`endif

// ===== hw/rtl/pcs_pkg.sv =====
// Shared types, codes and helpers for the preference closure store.
package pcs_pkg;

  localparam int CAND_W    = 6;
  localparam int CNT_W     = 6;
  localparam int STATUS_W  = 3;
  localparam int REL_W     = 2;
  localparam int MIN_COUNT = 2;

  localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

  localparam logic OP_QUERY  = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  localparam logic [REL_W-1:0] REL_UNKNOWN  = 2'd0;
  localparam logic [REL_W-1:0] REL_ROW_WINS = 2'd1;
  localparam logic [REL_W-1:0] REL_COL_WINS = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_SAME    = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_A_ABOVE = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_B_ABOVE = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_BAD     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_RD,
    ST_REC_A,
    ST_REC_B,
    ST_PIV_RD,
    ST_PIV_LD,
    ST_ROWS,
    ST_FIN_RD,
    ST_FIN,
    ST_RESULT
  } pcs_state_t;

  function automatic logic [REL_W-1:0] opposite_rel(input logic [REL_W-1:0] r);
    return (r == REL_ROW_WINS) ? REL_COL_WINS : REL_ROW_WINS;
  endfunction

  function automatic logic [STATUS_W-1:0] rel_to_status(input logic [REL_W-1:0] r);
    logic [STATUS_W-1:0] s;
    unique case (r)
      REL_ROW_WINS: s = STATUS_A_ABOVE;
      REL_COL_WINS: s = STATUS_B_ABOVE;
      default:      s = STATUS_UNKNOWN;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/pcs_if.sv =====
// Valid/ready channel interfaces for commands and responses.
interface pcs_cmd_if;
  import pcs_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [CAND_W-1:0] candidate_a;
  logic [CAND_W-1:0] candidate_b;
  logic              a_wins;

  modport source (output valid, opcode, candidate_a, candidate_b, a_wins, input ready);
  modport sink   (input valid, opcode, candidate_a, candidate_b, a_wins, output ready);
endinterface

interface pcs_rsp_if;
  import pcs_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

// ===== hw/rtl/pcs_matrix_mem.sv =====
// Row-wide preference matrix memory with per-row valid bits and registered read.
module pcs_matrix_mem #(
  parameter int MAX_CANDIDATES = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    rd_en,
  input  logic [$clog2(MAX_CANDIDATES)-1:0]       rd_addr,
  input  logic                                    wr_en,
  input  logic [$clog2(MAX_CANDIDATES)-1:0]       wr_addr,
  input  logic [pcs_pkg::REL_W*MAX_CANDIDATES-1:0] wr_data,
  output logic [pcs_pkg::REL_W*MAX_CANDIDATES-1:0] rd_row
);
  import pcs_pkg::*;

  localparam int RW = REL_W * MAX_CANDIDATES;

  logic [RW-1:0]             mem [MAX_CANDIDATES];
  logic [MAX_CANDIDATES-1:0] row_valid;
  logic [RW-1:0]             rd_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // A row never written since reset reads as all unknown.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid[rd_addr];
      end
    end
  end

  assign rd_row = rd_valid_q ? rd_q : '0;

`include "preference_closure_store_assert.svh"
  `PCS_ASSERT_NEVER(a_rw_same_row, clk, rst, rd_en && wr_en && rd_addr == wr_addr)

endmodule

// ===== hw/rtl/preference_closure_store.sv =====
// Preference closure store: a record runs a closure pass, which for each pivot reads
// the pivot row and then streams every row through the single read port and single
// write port of the row-wide matrix memory, one row a cycle. The matrix starts all
// unknown after reset with no clearing pass, and a finished response waits in an
// output register while a new command is taken.
module preference_closure_store #(
  parameter int MAX_CANDIDATES = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [pcs_pkg::CNT_W-1:0]   cfg_wr_data,
  pcs_cmd_if.sink                     cmd,
  pcs_rsp_if.source                   rsp
);
  import pcs_pkg::*;

  localparam int IW = $clog2(MAX_CANDIDATES);
  localparam int CW = $clog2(MAX_CANDIDATES + 1);
  localparam int RW = REL_W * MAX_CANDIDATES;

  pcs_state_t state, state_next;

  logic [CNT_W-1:0]    candidate_count;
  logic [CW-1:0]       n_eff;
  logic [IW-1:0]       ia, ib, k, ri, n_last;
  logic                a_wins_q;
  logic [RW-1:0]       piv;
  logic [STATUS_W-1:0] status_q, status_next;
  logic                rsp_valid_q;
  logic [STATUS_W-1:0] rsp_status_q;

  logic                mem_rd_en, mem_wr_en;
  logic [IW-1:0]       mem_rd_addr, mem_wr_addr;
  logic [RW-1:0]       mem_wr_data, rd_row, row_upd, rec_row;
  logic [REL_W-1:0]    c_rel, rec_rel;
  logic                a_bad, b_bad, out_load, cmd_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      candidate_count <= CNT_RESET;
    end else if (cfg_wr_en) begin
      candidate_count <= cfg_wr_data;
    end
  end

  always_comb begin
    if (int'(candidate_count) < MIN_COUNT) begin
      n_eff = CW'(MIN_COUNT);
    end else if (int'(candidate_count) > MAX_CANDIDATES) begin
      n_eff = CW'(MAX_CANDIDATES);
    end else begin
      n_eff = CW'(candidate_count);
    end
  end

  assign n_last = IW'(n_eff - CW'(1));

  assign a_bad = (cmd.candidate_a == '0) || (int'(cmd.candidate_a) > int'(n_eff));
  assign b_bad = (cmd.candidate_b == '0) || (int'(cmd.candidate_b) > int'(n_eff));

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  // Within one pivot the pivot row and column are never written, so each row
  // update only needs the latched pivot row and the row's own pivot column.
  // The mirror writes of the pass are produced by the mirrored row's own update.
  always_comb begin
    c_rel   = rd_row[{k, 1'b0} +: REL_W];
    row_upd = rd_row;
    for (int j = 0; j < MAX_CANDIDATES; j++) begin
      if (c_rel != REL_UNKNOWN && CW'(j) < n_eff && IW'(j) != k && IW'(j) != ri &&
          piv[REL_W*j +: REL_W] == c_rel) begin
        row_upd[REL_W*j +: REL_W] = c_rel;
      end
    end
  end

  // Record writes: row a gets the outcome, row b its mirror.
  always_comb begin
    rec_rel = a_wins_q ? REL_ROW_WINS : REL_COL_WINS;
    rec_row = rd_row;
    if (state == ST_REC_A) begin
      rec_row[{ib, 1'b0} +: REL_W] = rec_rel;
    end else begin
      rec_row[{ia, 1'b0} +: REL_W] = opposite_rel(rec_rel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ia;
    mem_wr_en   = 1'b0;
    mem_wr_addr = ri;
    mem_wr_data = row_upd;
    status_next = status_q;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          if (a_bad || b_bad) begin
            status_next = STATUS_BAD;
            state_next  = ST_RESULT;
          end else if (cmd.candidate_a == cmd.candidate_b) begin
            status_next = STATUS_SAME;
            state_next  = ST_RESULT;
          end else if (cmd.opcode == OP_RECORD) begin
            state_next = ST_REC_RD;
          end else begin
            state_next = ST_FIN_RD;
          end
        end
      end
      ST_REC_RD: begin
        mem_rd_en  = 1'b1;
        state_next = ST_REC_A;
      end
      ST_REC_A: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ia;
        mem_wr_data = rec_row;
        mem_rd_en   = 1'b1;
        mem_rd_addr = ib;
        state_next  = ST_REC_B;
      end
      ST_REC_B: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ib;
        mem_wr_data = rec_row;
        state_next  = ST_PIV_RD;
      end
      ST_PIV_RD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = k;
        state_next  = ST_PIV_LD;
      end
      ST_PIV_LD: begin
        mem_rd_en   = 1'b1;
        mem_rd_addr = '0;
        state_next  = ST_ROWS;
      end
      ST_ROWS: begin
        mem_wr_en = 1'b1;
        if (ri == n_last) begin
          state_next = (k == n_last) ? ST_FIN_RD : ST_PIV_RD;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = ri + IW'(1);
        end
      end
      ST_FIN_RD: begin
        mem_rd_en  = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        status_next = rel_to_status(rd_row[{ib, 1'b0} +: REL_W]);
        state_next  = ST_RESULT;
      end
      ST_RESULT: begin
        if (!rsp_valid_q || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    status_q <= status_next;
    if (cmd_fire) begin
      ia       <= IW'(cmd.candidate_a - CAND_W'(1));
      ib       <= IW'(cmd.candidate_b - CAND_W'(1));
      a_wins_q <= cmd.a_wins;
    end
    if (state == ST_PIV_LD) begin
      piv <= rd_row;
    end
    if (out_load) begin
      rsp_status_q <= status_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k           <= '0;
      ri          <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (state == ST_REC_B) begin
        k <= '0;
      end else if (state == ST_ROWS && ri == n_last) begin
        k <= k + IW'(1);
      end
      if (state == ST_PIV_LD) begin
        ri <= '0;
      end else if (state == ST_ROWS) begin
        ri <= ri + IW'(1);
      end
      if (out_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp.valid  = rsp_valid_q;
  assign rsp.status = rsp_status_q;

  pcs_matrix_mem #(
    .MAX_CANDIDATES(MAX_CANDIDATES)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_row  (rd_row)
  );

`include "preference_closure_store_assert.svh"
  `PCS_ASSERT_NEVER(a_row_in_range, clk, rst, state == ST_ROWS && CW'(ri) >= n_eff)
  `PCS_ASSERT_IMPL(a_rsp_from_result, clk, rst, $rose(rsp_valid_q), $past(state) == ST_RESULT)
  `PCS_ASSERT_NEXT(a_busy_after_cmd, clk, rst, cmd_fire, state != ST_IDLE)

endmodule

// ===== dv/preference_closure_store_tb.sv =====
// Self-checking testbench for the preference closure store with a built-in closure predictor.
module preference_closure_store_tb;
  import pcs_pkg::*;

  localparam int MAX_CAND    = 32;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 16;
  localparam int PHASE_ITEMS = 44;

  typedef struct packed {
    logic              opcode;
    logic [CAND_W-1:0] candidate_a;
    logic [CAND_W-1:0] candidate_b;
    logic              a_wins;
  } cmd_item_t;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  pcs_cmd_if cmd_ch ();
  pcs_rsp_if rsp_ch ();

  preference_closure_store #(
    .MAX_CANDIDATES(MAX_CAND)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd_ch),
    .rsp        (rsp_ch)
  );

  // Predictor state: the relation matrix and the candidate count register.
  logic [REL_W-1:0]    pref_rel [MAX_CAND][MAX_CAND];
  logic [CNT_W-1:0]    cand_count;

  cmd_item_t           pending_cmds [$];
  logic [STATUS_W-1:0] status_due [$];
  cmd_item_t           next_cmd;
  cmd_item_t           seen_cmd;
  logic [STATUS_W-1:0] want_status;

  int  queued_count;
  int  accepted_count;
  int  errors;
  int  cycle_count;
  int  send_gap;
  int  ready_hold;
  bit  steady;
  logic cmd_fire;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int live_count(input logic [CNT_W-1:0] raw);
    int n;
    n = int'(raw);
    if (n < MIN_COUNT) n = MIN_COUNT;
    if (n > MAX_CAND) n = MAX_CAND;
    return n;
  endfunction

  // Warshall pass in place, pivot outermost, mirror entry kept consistent.
  function automatic void close_transitively(input int n);
    logic [REL_W-1:0] r;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        if (i == k) continue;
        for (int j = 0; j < n; j++) begin
          if (j == k || j == i) continue;
          r = pref_rel[i][k];
          if (r != REL_UNKNOWN && r == pref_rel[k][j]) begin
            pref_rel[i][j] = r;
            pref_rel[j][i] = (r == REL_ROW_WINS) ? REL_COL_WINS : REL_ROW_WINS;
          end
        end
      end
    end
  endfunction

  function automatic logic [STATUS_W-1:0] apply_command(input cmd_item_t c);
    int n;
    int ia;
    int ib;
    logic [REL_W-1:0] v;
    n = live_count(cand_count);
    if (c.candidate_a == 0 || c.candidate_b == 0 || c.candidate_a > n || c.candidate_b > n)
      return STATUS_BAD;
    if (c.candidate_a == c.candidate_b) return STATUS_SAME;
    ia = c.candidate_a - 1;
    ib = c.candidate_b - 1;
    if (c.opcode == OP_RECORD) begin
      v = c.a_wins ? REL_ROW_WINS : REL_COL_WINS;
      pref_rel[ia][ib] = v;
      pref_rel[ib][ia] = (v == REL_ROW_WINS) ? REL_COL_WINS : REL_ROW_WINS;
      close_transitively(n);
    end
    case (pref_rel[ia][ib])
      REL_ROW_WINS: return STATUS_A_ABOVE;
      REL_COL_WINS: return STATUS_B_ABOVE;
      default:      return STATUS_UNKNOWN;
    endcase
  endfunction

  // Mostly back-to-back, some short pauses, a few long ones.
  function automatic int pick_stall();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CAND_W-1:0] pick_cand(input int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return CAND_W'($urandom_range(1, n));
    if (r < 93 || n >= 63) return '0;
    return CAND_W'($urandom_range(n + 1, 63));
  endfunction

  task automatic queue_cmd(input logic op, input int a, input int b, input logic aw);
    cmd_item_t c;
    c.opcode = op;
    c.candidate_a = CAND_W'(a);
    c.candidate_b = CAND_W'(b);
    c.a_wins = aw;
    pending_cmds = {pending_cmds, c};
    queued_count++;
  endtask

  task automatic write_count(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cand_count = value;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || accepted_count != queued_count || status_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Command driver: holds an item until its transfer, then an optional gap.
  always @(negedge clk) begin
    if (!rst) begin
      if (!cmd_ch.valid || cmd_fire) begin
        if (send_gap > 0) begin
          cmd_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_cmds.size() > 0) begin
          next_cmd = pending_cmds.pop_front();
          cmd_ch.opcode <= next_cmd.opcode;
          cmd_ch.candidate_a <= next_cmd.candidate_a;
          cmd_ch.candidate_b <= next_cmd.candidate_b;
          cmd_ch.a_wins <= next_cmd.a_wins;
          cmd_ch.valid <= 1'b1;
          send_gap <= pick_stall();
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response back-pressure.
  always @(negedge clk) begin
    if (!rst) begin
      if (ready_hold > 0) begin
        rsp_ch.ready <= 1'b0;
        ready_hold <= ready_hold - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        ready_hold <= pick_stall();
      end
    end
  end

  // Monitor: predicts on each command transfer and checks each response transfer.
  always @(posedge clk) begin
    if (rst) begin
      cmd_fire <= 1'b0;
    end else begin
      cmd_fire <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen_cmd.opcode = cmd_ch.opcode;
        seen_cmd.candidate_a = cmd_ch.candidate_a;
        seen_cmd.candidate_b = cmd_ch.candidate_b;
        seen_cmd.a_wins = cmd_ch.a_wins;
        status_due = {status_due, apply_command(seen_cmd)};
        accepted_count++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual status %0d",
                   $time, rsp_ch.status);
          errors++;
        end else begin
          want_status = status_due.pop_front();
          if (rsp_ch.status !== want_status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want_status, rsp_ch.status);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL preference_closure_store");
      $finish;
    end
  end

  initial begin : stimulus
    int counts [$];
    int rank [MAX_CAND];
    int n;
    int a;
    int b;
    int t;
    logic op;
    logic aw;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_QUERY;
    cmd_ch.candidate_a = '0;
    cmd_ch.candidate_b = '0;
    cmd_ch.a_wins = 1'b0;
    rsp_ch.ready = 1'b0;
    cmd_fire = 1'b0;
    send_gap = 0;
    ready_hold = 0;
    steady = 1'b0;
    queued_count = 0;
    accepted_count = 0;
    errors = 0;
    cycle_count = 0;
    cand_count = CNT_RESET;
    for (int i = 0; i < MAX_CAND; i++)
      for (int j = 0; j < MAX_CAND; j++)
        pref_rel[i][j] = REL_UNKNOWN;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset count of 32.
    queue_cmd(OP_QUERY, 1, 2, 1'b0);
    queue_cmd(OP_QUERY, 7, 7, 1'b1);
    queue_cmd(OP_QUERY, 0, 5, 1'b0);
    queue_cmd(OP_QUERY, 5, 0, 1'b1);
    queue_cmd(OP_QUERY, 33, 4, 1'b0);
    queue_cmd(OP_QUERY, 63, 63, 1'b1);
    queue_cmd(OP_RECORD, 1, 2, 1'b1);
    queue_cmd(OP_RECORD, 2, 3, 1'b1);
    queue_cmd(OP_QUERY, 1, 3, 1'b0);
    queue_cmd(OP_QUERY, 3, 1, 1'b0);
    // A record that contradicts what the closure derived overwrites it.
    queue_cmd(OP_RECORD, 3, 1, 1'b1);
    queue_cmd(OP_QUERY, 1, 3, 1'b0);
    queue_cmd(OP_RECORD, 4, 4, 1'b1);
    queue_cmd(OP_RECORD, 0, 4, 1'b0);
    queue_cmd(OP_RECORD, 32, 31, 1'b0);
    queue_cmd(OP_RECORD, 31, 30, 1'b0);
    queue_cmd(OP_QUERY, 32, 30, 1'b1);
    queue_cmd(OP_RECORD, 1, 63, 1'b1);
    queue_cmd(OP_RECORD, 32, 33, 1'b0);
    queue_cmd(OP_QUERY, 31, 32, 1'b0);
    drain();

    // Counts below 2 and above the maximum are covered along with ordinary ones.
    counts = '{2, 0, 1, 63, 33, 5, 8, 12, 3, 32, 20, 7};
    foreach (counts[p]) begin
      write_count(CNT_W'(counts[p]));
      n = live_count(cand_count);
      steady = ($urandom_range(0, 3) == 0);

      // A hidden ranking per phase makes most records consistent, so long chains form.
      for (int i = 0; i < MAX_CAND; i++) rank[i] = i;
      for (int i = MAX_CAND - 1; i > 0; i--) begin
        b = $urandom_range(0, i);
        t = rank[i];
        rank[i] = rank[b];
        rank[b] = t;
      end

      for (int m = 0; m < PHASE_ITEMS; m++) begin
        op = ($urandom_range(0, 99) < 45) ? OP_RECORD : OP_QUERY;
        a = pick_cand(n);
        b = ($urandom_range(0, 99) < 8) ? a : pick_cand(n);
        if (a >= 1 && b >= 1 && a <= n && b <= n && a != b && $urandom_range(0, 9) != 0)
          aw = (rank[a - 1] < rank[b - 1]);
        else
          aw = 1'($urandom_range(0, 1));
        queue_cmd(op, a, b, aw);
      end
      drain();
    end

    if (status_due.size() != 0) begin
      $display("%0t: %0d expected responses never arrived", $time, status_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS preference_closure_store");
    end else begin
      $display("FAIL preference_closure_store");
    end
    $finish;
  end

endmodule
